/* rtl/lru_key_value_cache_assert.svh */
// Assertion macros used by the cache controller RTL. They expect clk and rst_n in scope.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define LKV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkv assertion failed");
`define LKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkv assertion failed");
`else
`define LKV_ASSERT_IMP(lbl, ante, cons)
`define LKV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/lkv_pkg.sv */
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 16;
  localparam int VAL_W       = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lkv_state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_HIT,
    OP_FILL,
    OP_EVICT
  } lkv_op_t;

  typedef struct packed {
    logic                    cmd;
    logic [KEY_W-1:0]        lookup_key;
    logic signed [VAL_W-1:0] write_value;
  } lkv_req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } lkv_rsp_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    lkv_op_t           op;
    logic              wr_value;
    logic [RANK_W-1:0] ref_rank;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } lkv_ctl_t;

  // Passed from each cell to the next one up the row.
  typedef struct packed {
    logic              hit;
    logic              free;
    logic [RANK_W-1:0] rank;
    logic [VAL_W-1:0]  value;
  } lkv_link_t;

endpackage

/* rtl/lkv_cell.sv */
module lkv_cell import lkv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lkv_ctl_t  ctl,
  input  lkv_link_t lk_in,
  output lkv_link_t lk_out
);

  logic              valid_r, valid_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;

  logic match;
  logic first_hit;
  logic first_free;
  logic target;
  logic age;

  always_comb begin
    match      = valid_r && (key_r == ctl.key);
    first_hit  = match && !lk_in.hit;
    first_free = !valid_r && !lk_in.free;

    // Keys are unique, so at most one cell ORs its rank and value in.
    lk_out.hit   = lk_in.hit | match;
    lk_out.free  = lk_in.free | !valid_r;
    lk_out.rank  = lk_in.rank | (first_hit ? rank_r : '0);
    lk_out.value = lk_in.value | (first_hit ? value_r : '0);
  end

  always_comb begin
    case (ctl.op)
      OP_HIT:   target = first_hit;
      OP_FILL:  target = first_free;
      OP_EVICT: target = valid_r && (rank_r == ctl.ref_rank);
      default:  target = 1'b0;
    endcase
    case (ctl.op)
      OP_FILL:         age = valid_r;
      OP_HIT, OP_EVICT: age = valid_r && (rank_r < ctl.ref_rank);
      default:         age = 1'b0;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r | target;
    key_nxt   = (target && ctl.op != OP_HIT) ? ctl.key : key_r;
    value_nxt = (target && (ctl.op != OP_HIT || ctl.wr_value)) ? ctl.value : value_r;
    if (target) begin
      rank_nxt = '0;
    end else if (age) begin
      rank_nxt = rank_r + RANK_W'(1);
    end else begin
      rank_nxt = rank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    rank_r  <= rank_nxt;
  end

endmodule

/* rtl/lkv_ctrl.sv */
`include "lru_key_value_cache_assert.svh"
module lkv_ctrl import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lkv_req_t         in_req,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  lkv_link_t        chain_end,
  output lkv_ctl_t         ctl,
  output logic             out_valid,
  output lkv_rsp_t         out_rsp
);

  lkv_state_t state_r, state_nxt;

  lkv_req_t          req_r, req_nxt;
  logic [CAP_W-1:0]  capacity_r, capacity_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              hit_r, hit_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              out_valid_r, out_valid_nxt;
  lkv_rsp_t          out_rsp_r, out_rsp_nxt;

  logic [CNT_W-1:0] cap_eff;
  lkv_op_t          op_sel;

  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity_r) > MAX_ENTRIES) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity_r);
    end

    if (hit_r) begin
      op_sel = OP_HIT;
    end else if (req_r.cmd == CMD_PUT) begin
      op_sel = (fill_r < cap_eff) ? OP_FILL : OP_EVICT;
    end else begin
      op_sel = OP_NONE;
    end
  end

  // Next state.
  always_comb begin
    case (state_r)
      ST_IDLE:   state_nxt = start ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    busy         = (state_r != ST_IDLE);
    req_nxt      = req_r;
    capacity_nxt = cfg_we ? cfg_wdata : capacity_r;
    fill_nxt     = fill_r;
    hit_nxt      = hit_r;
    rank_nxt     = rank_r;
    val_nxt      = val_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;

    ctl.op       = OP_NONE;
    ctl.wr_value = (req_r.cmd == CMD_PUT);
    // The least recent valid entry always holds rank fill_count - 1.
    ctl.ref_rank = (op_sel == OP_EVICT) ? RANK_W'(fill_r - CNT_W'(1)) : rank_r;
    ctl.key      = req_r.lookup_key;
    ctl.value    = req_r.write_value;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_req;
        end
      end
      ST_LOOKUP: begin
        hit_nxt  = chain_end.hit;
        rank_nxt = chain_end.rank;
        val_nxt  = chain_end.value;
      end
      ST_UPDATE: begin
        ctl.op        = op_sel;
        out_valid_nxt = 1'b1;
        out_rsp_nxt.hit        = hit_r;
        out_rsp_nxt.read_value = (hit_r && req_r.cmd == CMD_GET) ? val_r : '0;
        if (op_sel == OP_FILL) begin
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    out_valid = out_valid_r;
    out_rsp   = out_rsp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= CAP_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    hit_r     <= hit_nxt;
    rank_r    <= rank_nxt;
    val_r     <= val_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  `LKV_ASSERT_NEXT(a_accept_to_lookup, state_r == ST_IDLE && start, state_r == ST_LOOKUP)
  `LKV_ASSERT_NEXT(a_update_gives_result, state_r == ST_UPDATE, out_valid_r && !busy)
  `LKV_ASSERT_IMP(a_fill_bounded, 1'b1, int'(fill_r) <= MAX_ENTRIES)
  `LKV_ASSERT_IMP(a_miss_reads_zero, out_valid_r && !out_rsp_r.hit, out_rsp_r.read_value == '0)
  `LKV_ASSERT_IMP(a_fill_needs_room, ctl.op == OP_FILL, chain_end.free)

endmodule

/* rtl/lru_key_value_cache.sv */
// A request taken with start goes through the steps accept, lookup through the cell row
// and update of the cells; out_valid is registered from the update step. busy is high in
// lookup and update, and start is ignored then, so no new request is taken before the last is through.
// Reset (rst_n low, synchronous) clears all valid bits and the fill count and sets
// capacity to 16. Results are strobed for one cycle; the receiver cannot stall.
module lru_key_value_cache import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lkv_req_t         in_req,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output logic             out_valid,
  output lkv_rsp_t         out_rsp
);

  lkv_ctl_t  ctl;
  lkv_link_t link [MAX_ENTRIES+1];

  assign link[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .lk_in  (link[i]),
      .lk_out (link[i+1])
    );
  end

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .chain_end (link[MAX_ENTRIES]),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
